[rtl/core/utf_pkg.sv]
// Package: shared types and constants for the UTF-16 to UTF-8 converter.
`timescale 1ns / 1ps
`default_nettype none

package utf_pkg;

  // Bundle queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoAw + 1;

  // Surrogate classes: top six bits of the code unit
  localparam logic [5:0] SurrHighTag = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] SurrLowTag  = 6'b110111;  // 0xDC00..0xDFFF

  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [7:0]  ErrByte   = 8'h3F;
  localparam logic [1:0]  ContTag   = 2'b10;   // 0x80 continuation prefix
  localparam logic [2:0]  Lead2Tag  = 3'b110;  // 0xC0
  localparam logic [3:0]  Lead3Tag  = 4'b1110; // 0xE0
  localparam logic [4:0]  Lead4Tag  = 5'b11110; // 0xF0

  // One decoded unit: up to four bytes, first byte in slot 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } utf_bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } utf_fifo_status_t;

endpackage

`default_nettype wire

[rtl/core/utf_if.sv]
// Interfaces: UTF-16 code unit channel and UTF-8 byte channel.
`timescale 1ns / 1ps
`default_nettype none

interface utf16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_buffer;

  modport source (output valid, output code_unit, output end_of_buffer, input ready);
  modport sink   (input valid, input code_unit, input end_of_buffer, output ready);
endinterface

interface utf8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       last_of_run;

  modport source (output valid, output utf8_byte, output last_of_run, input ready);
  modport sink   (input valid, input utf8_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/core/utf_front.sv]
// Front end: accepts code units, tracks the held high surrogate, builds byte bundles.
`timescale 1ns / 1ps
`default_nettype none

module utf_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [15:0]               code_unit_i,
  input  wire logic                      end_of_buffer_i,
  input  wire utf_pkg::utf_fifo_status_t fifo_status_i,
  output      logic                      push_o,
  output      utf_pkg::utf_bundle_t      bundle_o
);

  logic       pend_valid_q, pend_valid_d;
  logic [9:0] pend_bits_q, pend_bits_d;

  logic            accept;
  logic            is_high, is_low;
  logic [3:0][7:0] fresh;
  logic [1:0]      fresh_n;
  logic [20:0]     cp;

  assign in_ready_o = !fifo_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign is_high = (code_unit_i[15:10] == utf_pkg::SurrHighTag);
  assign is_low  = (code_unit_i[15:10] == utf_pkg::SurrLowTag);
  assign cp      = {1'b0, pend_bits_q, code_unit_i[9:0]} + utf_pkg::SuppBase;

  // Encoding of the unit as if nothing were held
  always_comb begin
    fresh   = '0;
    fresh_n = 2'd0;
    if (code_unit_i[15:7] == 9'd0) begin
      fresh[0] = code_unit_i[7:0];
      fresh_n  = 2'd1;
    end else if (code_unit_i[15:11] == 5'd0) begin
      fresh[0] = {utf_pkg::Lead2Tag, code_unit_i[10:6]};
      fresh[1] = {utf_pkg::ContTag, code_unit_i[5:0]};
      fresh_n  = 2'd2;
    end else if (is_high) begin
      fresh_n  = 2'd0;
    end else if (is_low) begin
      fresh[0] = utf_pkg::ErrByte;
      fresh_n  = 2'd1;
    end else begin
      fresh[0] = {utf_pkg::Lead3Tag, code_unit_i[15:12]};
      fresh[1] = {utf_pkg::ContTag, code_unit_i[11:6]};
      fresh[2] = {utf_pkg::ContTag, code_unit_i[5:0]};
      fresh_n  = 2'd3;
    end
  end

  always_comb begin
    bundle_o = '0;
    push_o   = 1'b0;
    if (pend_valid_q && is_low) begin
      bundle_o.bytes[0] = {utf_pkg::Lead4Tag, cp[20:18]};
      bundle_o.bytes[1] = {utf_pkg::ContTag, cp[17:12]};
      bundle_o.bytes[2] = {utf_pkg::ContTag, cp[11:6]};
      bundle_o.bytes[3] = {utf_pkg::ContTag, cp[5:0]};
      bundle_o.last_idx = 2'd3;
      push_o            = accept;
    end else if (pend_valid_q) begin
      // broken pair: '?' then the unit encoded afresh
      bundle_o.bytes    = {fresh[2:0], utf_pkg::ErrByte};
      bundle_o.last_idx = fresh_n;
      push_o            = accept;
    end else begin
      bundle_o.bytes    = fresh;
      bundle_o.last_idx = fresh_n - 2'd1;
      push_o            = accept && (fresh_n != 2'd0);
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_bits_d  = pend_bits_q;
    if (accept) begin
      if (is_high && !(pend_valid_q && is_low)) begin
        pend_valid_d = 1'b1;
        pend_bits_d  = code_unit_i[9:0];
      end else begin
        pend_valid_d = 1'b0;
        pend_bits_d  = '0;
      end
      if (end_of_buffer_i) begin
        pend_valid_d = 1'b0;
        pend_bits_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_bits_q  <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_bits_q  <= pend_bits_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/utf_fifo.sv]
// Short bundle queue between front end and byte serializer.
`timescale 1ns / 1ps
`default_nettype none

module utf_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire utf_pkg::utf_bundle_t      push_data_i,
  input  wire logic                      pop_i,
  output      utf_pkg::utf_bundle_t      head_o,
  output      utf_pkg::utf_fifo_status_t status_o
);

  utf_pkg::utf_bundle_t mem_q [utf_pkg::FifoDepth];

  logic [utf_pkg::FifoAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [utf_pkg::FifoAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [utf_pkg::FifoCntW-1:0] count_q, count_d;
  logic                         do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == utf_pkg::FifoCntW'(utf_pkg::FifoDepth));
  assign head_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  function automatic logic [utf_pkg::FifoAw-1:0] ptr_inc(
    input logic [utf_pkg::FifoAw-1:0] p
  );
    if (p == utf_pkg::FifoAw'(utf_pkg::FifoDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/utf_back.sv]
// Back end: serializes queued bundles into an output byte register.
`timescale 1ns / 1ps
`default_nettype none

module utf_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire utf_pkg::utf_bundle_t      head_i,
  input  wire utf_pkg::utf_fifo_status_t fifo_status_i,
  output      logic                      pop_o,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [7:0]                utf8_byte_o,
  output      logic                      last_of_run_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [1:0] idx_q, idx_d;
  logic       load, at_last;

  // output register refills when empty or its byte is taken this cycle, and the queue holds a bundle
  assign load    = (!out_valid_q || out_ready_i) && !fifo_status_i.empty;
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      byte_d      = head_i.bytes[idx_q];
      last_d      = at_last;
      idx_d       = at_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign utf8_byte_o   = byte_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

[rtl/core/utf16_to_utf8_converter_core.sv]
// Top level: UTF-16 code unit stream to UTF-8 byte stream converter.
//
// Channels: unit_i takes one 16-bit UTF-16 code unit per transfer, with
// end_of_buffer marking the last unit of a buffer. byte_o gives one UTF-8
// byte per transfer; last_of_run marks the final byte caused by one unit.
// A high surrogate is held and gives no byte; a following low surrogate
// gives four bytes; a broken pair gives '?' and the unit is encoded anew;
// a lone low surrogate gives '?'. A high surrogate held at end of buffer
// is dropped.
// Path: an accepted unit is written into the bundle queue, and its first
// byte is then loaded into the output byte register that drives byte_o.
// Throughput: the serializer emits one byte per cycle while byte_o is
// taken and the queue is not empty; a unit gives one byte for ASCII and
// up to four bytes for a surrogate pair or a broken pair, and units that
// give no byte put nothing in the queue. The front accepts a unit every
// cycle while the two-entry bundle queue has room.
// Reset (rst_ni low, asynchronous): nothing held, queue empty, byte_o
// not valid.
// Stall: when byte_o is not taken, the byte holds, the queue fills, and
// unit_i.ready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_converter_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  utf16_unit_if.sink  unit_i,
  utf8_byte_if.source byte_o
);

  utf_pkg::utf_bundle_t      push_bundle;
  utf_pkg::utf_bundle_t      head_bundle;
  utf_pkg::utf_fifo_status_t fifo_status;
  logic                      push, pop;

  // Front: classify units, handle surrogate pairing
  utf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (unit_i.valid),
    .in_ready_o      (unit_i.ready),
    .code_unit_i     (unit_i.code_unit),
    .end_of_buffer_i (unit_i.end_of_buffer),
    .fifo_status_i   (fifo_status),
    .push_o          (push),
    .bundle_o        (push_bundle)
  );

  // Decouples unit acceptance from byte emission
  utf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head_bundle),
    .status_o    (fifo_status)
  );

  // Back: one byte per cycle into the output register while byte_o is taken and the queue is not empty
  utf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_bundle),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (byte_o.valid),
    .out_ready_i   (byte_o.ready),
    .utf8_byte_o   (byte_o.utf8_byte),
    .last_of_run_o (byte_o.last_of_run)
  );

endmodule

`default_nettype wire

[rtl/core/utf_checker.sv]
// Checker: port-level assertions for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module utf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);

  // stalled byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled output byte changed");

  // a multi-byte lead byte always has continuation bytes after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_byte_i[7:6] == 2'b11) |-> !out_last_i)
    else $error("lead byte marked last of run");

  // no 0xF8..0xFF and no overlong two-byte leads 0xC0/0xC1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_byte_i[7:3] != 5'b11111) && (out_byte_i[7:1] != 7'b1100000))
    else $error("illegal UTF-8 byte");

  // four-byte lead stays at or below 0xF4
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_byte_i[7:3] == 5'b11110) |-> (out_byte_i[2:0] <= 3'd4))
    else $error("code point beyond U+10FFFF");

endmodule

bind utf16_to_utf8_converter_core utf_checker u_utf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_byte_i  (byte_o.utf8_byte),
  .out_last_i  (byte_o.last_of_run)
);

`default_nettype wire
